[sv/stit_pkg.sv]
// Shared types and constants for the session table.
package stit_pkg;

	localparam logic [2:0] KIND_CREATE   = 3'd0;
	localparam logic [2:0] KIND_VALIDATE = 3'd1;
	localparam logic [2:0] KIND_DESTROY  = 3'd2;
	localparam logic [2:0] KIND_SWEEP    = 3'd3;
	localparam logic [2:0] KIND_QUERY    = 3'd4;

	localparam logic [2:0] ST_DONE    = 3'd0;
	localparam logic [2:0] ST_VALID   = 3'd1;
	localparam logic [2:0] ST_EXPIRED = 3'd2;
	localparam logic [2:0] ST_NOMATCH = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;

	localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_MAX_TOTAL    = 2'd1;
	localparam logic [1:0] REG_MAX_PER_ADDR = 2'd2;

	localparam logic [31:0] IDLE_TIMEOUT_RST = 32'd1800000;
	localparam logic [4:0]  MAX_TOTAL_RST    = 5'd10;
	localparam logic [4:0]  MAX_PER_ADDR_RST = 5'd3;

	typedef struct packed {
		logic [31:0] idle_timeout_ms;
		logic [4:0]  max_sessions_total;
		logic [4:0]  max_sessions_per_address;
	} cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_CHKFULL,
		S_INSERT,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		P_ADDR,
		P_ALL,
		P_MATCH,
		P_SWEEP
	} pass_t;

endpackage

[sv/session_table_with_idle_timeout_top.sv]
// Session table with idle timeout: top level with register port.
// Usage:
//   Requests: drive kind, client_address, token_high/low and now_ms with start
//   high; the request is taken at an edge where busy is low. busy stays high
//   until the result has been shown.
//   Results: ok, status, eviction flags and session_count hold for the single
//   cycle that done is high. There is no backpressure; the receiver must take
//   the result in that cycle.
//   Registers: APB-style, idle timeout at 0x0, table limit at 0x4,
//   per-address limit at 0x8; write only while busy is low.
// Timing: every scan reads one slot per cycle from the slot memories. Validate,
//   destroy and sweep make one pass over the table; create makes one pass, or two
//   when the table is full; query, empty-token and unknown requests make none.
//   One request is in flight at a time.
// Reset: the table is empty and registers take their defaults at once;
//   no clearing pass is needed.
module session_table_with_idle_timeout_top import stit_pkg::*; #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         start,
	output logic         busy,
	input  logic [2:0]   kind,
	input  logic [31:0]  client_address,
	input  logic [63:0]  token_high,
	input  logic [63:0]  token_low,
	input  logic [31:0]  now_ms,
	output logic         done,
	output logic         ok,
	output logic [2:0]   status,
	output logic         evicted_same_address,
	output logic         evicted_oldest,
	output logic [4:0]   session_count
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_timeout_ms          <= IDLE_TIMEOUT_RST;
			cfg_q.max_sessions_total       <= MAX_TOTAL_RST;
			cfg_q.max_sessions_per_address <= MAX_PER_ADDR_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_IDLE_TIMEOUT: cfg_q.idle_timeout_ms          <= pwdata;
				REG_MAX_TOTAL:    cfg_q.max_sessions_total       <= pwdata[4:0];
				REG_MAX_PER_ADDR: cfg_q.max_sessions_per_address <= pwdata[4:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_IDLE_TIMEOUT: prdata = cfg_q.idle_timeout_ms;
			REG_MAX_TOTAL:    prdata = {27'd0, cfg_q.max_sessions_total};
			REG_MAX_PER_ADDR: prdata = {27'd0, cfg_q.max_sessions_per_address};
			default:          prdata = '0;
		endcase
	end

	stit_core #(.TABLE_SLOTS(TABLE_SLOTS)) u_core (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg                  (cfg_q),
		.start                (start),
		.kind                 (kind),
		.client_address       (client_address),
		.token_high           (token_high),
		.token_low            (token_low),
		.now_ms               (now_ms),
		.busy                 (busy),
		.done                 (done),
		.ok                   (ok),
		.status               (status),
		.evicted_same_address (evicted_same_address),
		.evicted_oldest       (evicted_oldest),
		.session_count        (session_count)
	);

endmodule

[sv/stit_ram.sv]
// Generic single write port RAM with registered read.
module stit_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/stit_core.sv]
// Session table engine: slot memories, scan pipeline and request sequencer.
module stit_core import stit_pkg::*; #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         start,
	input  logic [2:0]   kind,
	input  logic [31:0]  client_address,
	input  logic [63:0]  token_high,
	input  logic [63:0]  token_low,
	input  logic [31:0]  now_ms,
	output logic         busy,
	output logic         done,
	output logic         ok,
	output logic [2:0]   status,
	output logic         evicted_same_address,
	output logic         evicted_oldest,
	output logic [4:0]   session_count
);

	localparam int IW   = $clog2(TABLE_SLOTS);
	localparam int CW   = $clog2(TABLE_SLOTS + 1);
	localparam int CMPW = (CW > 5) ? CW : 5;
	localparam int MW   = 32 + 128 + 32;
	localparam logic [IW-1:0]   LAST_IDX = IW'(TABLE_SLOTS - 1);
	localparam logic [CMPW-1:0] SLOTS_C  = CMPW'(TABLE_SLOTS);

	state_t state_q, state_d;
	pass_t  pass_q;

	logic [2:0]   kind_q;
	logic [31:0]  addr_q;
	logic [63:0]  th_q, tl_q;
	logic [31:0]  now_q;

	logic [IW-1:0] cnt_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	logic [TABLE_SLOTS-1:0] used_q;
	logic [TABLE_SLOTS-1:0] active_q;
	logic [IW-1:0]          rank_q [TABLE_SLOTS];
	logic [CW-1:0]          count_q;

	logic          found_q;
	logic [IW-1:0] best_q;
	logic [IW-1:0] best_rank_q;
	logic [31:0]   best_age_q;
	logic [31:0]   best_last_q;
	logic [CW-1:0] match_cnt_q;

	logic         ok_q, ev_addr_q, ev_old_q;
	logic [2:0]   status_q;

	logic [MW-1:0] rd_main;
	logic [31:0]   rd_last;

	// request view
	logic accept, empty;
	assign accept = start && (state_q == S_IDLE);
	assign empty  = (token_high == 64'd0) && (token_low == 64'd0);

	// limits
	logic [CMPW-1:0] lim, count_c;
	logic            full;
	assign lim     = (CMPW'(cfg.max_sessions_total) > SLOTS_C) ?
		SLOTS_C : CMPW'(cfg.max_sessions_total);
	assign count_c = CMPW'(count_q);
	assign full    = count_c >= lim;

	// slot under inspection
	logic [31:0]   r_addr, r_created;
	logic [63:0]   r_th, r_tl;
	logic          used_i, act_i, addr_eq, tok_eq, idle_i, cand, better;
	logic [IW-1:0] rank_i;
	logic [31:0]   age_i;

	assign {r_addr, r_th, r_tl, r_created} = rd_main;

	always_comb begin
		used_i  = used_q[idx_s1];
		act_i   = active_q[idx_s1];
		rank_i  = rank_q[idx_s1];
		addr_eq = (r_addr == addr_q);
		tok_eq  = (r_th == th_q) && (r_tl == tl_q);
		age_i   = now_q - r_created;
		idle_i  = (now_q - rd_last) > cfg.idle_timeout_ms;
		cand    = 1'b0;
		better  = 1'b0;
		case (pass_q)
			P_ADDR: begin
				cand   = used_i && act_i && addr_eq;
				better = !found_q || (age_i > best_age_q) ||
					((age_i == best_age_q) && (rank_i < best_rank_q));
			end
			P_ALL: begin
				cand   = used_i;
				better = !found_q || (age_i > best_age_q) ||
					((age_i == best_age_q) && (rank_i < best_rank_q));
			end
			P_MATCH: begin
				cand   = used_i && tok_eq &&
					((kind_q == KIND_DESTROY) || (act_i && addr_eq));
				better = !found_q || (rank_i < best_rank_q);
			end
			default: begin
				cand   = used_i && (!act_i || idle_i);
				better = 1'b0;
			end
		endcase
	end

	logic pick;
	assign pick = vld_s1 && cand && better && (pass_q != P_SWEEP);

	// first free slot
	logic [IW-1:0] free_idx;
	logic          free_found;
	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int j = TABLE_SLOTS - 1; j >= 0; j--) begin
			if (!used_q[j]) begin
				free_idx   = IW'(j);
				free_found = 1'b1;
			end
		end
	end

	logic best_idle, addr_over;
	assign best_idle = (now_q - best_last_q) > cfg.idle_timeout_ms;
	assign addr_over = CMPW'(match_cnt_q) >= CMPW'(cfg.max_sessions_per_address);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (((kind == KIND_CREATE) || (kind == KIND_VALIDATE)) && !empty) begin
						state_d = S_SCAN;
					end else if ((kind == KIND_DESTROY) || (kind == KIND_SWEEP)) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (cnt_q == LAST_IDX) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN:   state_d = S_DECIDE;
			S_DECIDE: begin
				if (pass_q == P_ADDR) begin
					state_d = S_CHKFULL;
				end else if (pass_q == P_ALL) begin
					state_d = S_INSERT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_CHKFULL: state_d = full ? S_SCAN : S_INSERT;
			S_INSERT:  state_d = S_DONE;
			S_DONE:    state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// control outputs
	logic          drop_en, ins_en, deact_en, last_wr;
	logic [IW-1:0] drop_idx, drop_rank;
	always_comb begin
		drop_en   = 1'b0;
		drop_idx  = best_q;
		drop_rank = best_rank_q;
		ins_en    = 1'b0;
		deact_en  = 1'b0;
		last_wr   = 1'b0;
		case (state_q)
			S_SCAN, S_DRAIN: begin
				if (vld_s1 && (pass_q == P_SWEEP) && cand) begin
					drop_en   = 1'b1;
					drop_idx  = idx_s1;
					drop_rank = rank_i;
				end
			end
			S_DECIDE: begin
				case (pass_q)
					P_ADDR:  drop_en = found_q && addr_over;
					P_ALL:   drop_en = found_q;
					P_MATCH: begin
						if (kind_q == KIND_DESTROY) begin
							drop_en = found_q;
						end else begin
							deact_en = found_q && best_idle;
							last_wr  = found_q && !best_idle;
						end
					end
					default: drop_en = 1'b0;
				endcase
			end
			S_INSERT: ins_en = !full && free_found;
			default:  drop_en = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pass_q   <= P_ADDR;
			cnt_q    <= '0;
			vld_s1   <= 1'b0;
			used_q   <= '0;
			count_q  <= '0;
			found_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == S_SCAN);
			if (state_q == S_SCAN) begin
				cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
			end
			if (accept) begin
				case (kind)
					KIND_CREATE:   pass_q <= P_ADDR;
					KIND_SWEEP:    pass_q <= P_SWEEP;
					default:       pass_q <= P_MATCH;
				endcase
			end
			if ((state_q == S_CHKFULL) && full) begin
				pass_q <= P_ALL;
			end
			if ((state_q == S_IDLE) || (state_q == S_CHKFULL)) begin
				found_q <= 1'b0;
			end else if (pick) begin
				found_q <= 1'b1;
			end
			if (drop_en) begin
				used_q[drop_idx] <= 1'b0;
				if (count_q != '0) begin
					count_q <= count_q - 1'b1;
				end
			end
			if (ins_en) begin
				used_q[free_idx] <= 1'b1;
				count_q          <= count_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (accept) begin
			kind_q    <= kind;
			addr_q    <= client_address;
			th_q      <= token_high;
			tl_q      <= token_low;
			now_q     <= now_ms;
			ev_addr_q <= 1'b0;
			ev_old_q  <= 1'b0;
			ok_q      <= (kind == KIND_QUERY);
			if (kind == KIND_QUERY) begin
				status_q <= ST_DONE;
			end else if (((kind == KIND_CREATE) || (kind == KIND_VALIDATE)) && empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_NOMATCH;
			end
		end
		if ((state_q == S_IDLE) || (state_q == S_CHKFULL)) begin
			match_cnt_q <= '0;
		end else if (vld_s1 && cand && (pass_q == P_ADDR)) begin
			match_cnt_q <= match_cnt_q + 1'b1;
		end
		if (pick) begin
			best_q      <= idx_s1;
			best_rank_q <= rank_i;
			best_age_q  <= age_i;
			best_last_q <= rd_last;
		end
		if (drop_en) begin
			for (int j = 0; j < TABLE_SLOTS; j++) begin
				if (rank_q[j] > drop_rank) begin
					rank_q[j] <= rank_q[j] - 1'b1;
				end
			end
		end
		if (ins_en) begin
			rank_q[free_idx]   <= count_q[IW-1:0];
			active_q[free_idx] <= 1'b1;
		end
		if (deact_en) begin
			active_q[best_q] <= 1'b0;
		end
		if (state_q == S_DECIDE) begin
			case (pass_q)
				P_ADDR: ev_addr_q <= drop_en;
				P_ALL:  ev_old_q  <= drop_en;
				P_MATCH: begin
					if (!found_q) begin
						status_q <= ST_NOMATCH;
					end else if (kind_q == KIND_DESTROY) begin
						ok_q     <= 1'b1;
						status_q <= ST_DONE;
					end else if (best_idle) begin
						status_q <= ST_EXPIRED;
					end else begin
						ok_q     <= 1'b1;
						status_q <= ST_VALID;
					end
				end
				default: begin
					ok_q     <= 1'b1;
					status_q <= ST_DONE;
				end
			endcase
		end
		if (state_q == S_INSERT) begin
			ok_q     <= ins_en;
			status_q <= ins_en ? ST_DONE : ST_EMPTY;
		end
	end

	// address, tokens and creation time; last activity apart so validate can refresh it
	stit_ram #(.WIDTH(MW), .DEPTH(TABLE_SLOTS)) u_main_ram (
		.clk   (clk),
		.we    (ins_en),
		.waddr (free_idx),
		.wdata ({addr_q, th_q, tl_q, now_q}),
		.raddr (cnt_q),
		.rdata (rd_main)
	);

	stit_ram #(.WIDTH(32), .DEPTH(TABLE_SLOTS)) u_last_ram (
		.clk   (clk),
		.we    (ins_en || last_wr),
		.waddr (ins_en ? free_idx : best_q),
		.wdata (now_q),
		.raddr (cnt_q),
		.rdata (rd_last)
	);

	assign busy                 = (state_q != S_IDLE);
	assign done                 = (state_q == S_DONE);
	assign ok                   = ok_q;
	assign status               = status_q;
	assign evicted_same_address = ev_addr_q;
	assign evicted_oldest       = ev_old_q;
	assign session_count        = 5'(count_c);

endmodule

[sv/stit_chk.sv]
// Port-level checks for the session table, bound to the top level.
module stit_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// a taken request holds the block busy
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but block not busy");

	// each result is a single-cycle strobe
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while idle");

	// busy only drops after the result went out
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("busy dropped without a result");

endmodule

bind session_table_with_idle_timeout_top stit_chk u_stit_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

[bench/tb_top.sv]
// Testbench for the session table: random and directed requests checked against a local model.
`timescale 1ns / 1ps

module tb_top;
	import stit_pkg::*;

	localparam int SLOTS = 16;

	typedef struct packed {
		logic       ok;
		logic [2:0] status;
		logic       ev_addr;
		logic       ev_old;
		logic [4:0] count;
	} outcome_t;

	class session_board;
		bit          used [SLOTS];
		bit          active [SLOTS];
		bit [31:0]   addr [SLOTS];
		bit [63:0]   th [SLOTS];
		bit [63:0]   tl [SLOTS];
		bit [31:0]   created [SLOTS];
		bit [31:0]   last [SLOTS];
		int unsigned order [SLOTS];
		int unsigned count;
		bit [31:0]   idle_to;
		bit [4:0]    max_total;
		bit [4:0]    max_addr;
		outcome_t    pending[$];
		int          mismatches;
		int          checked;

		function void clear();
			foreach (used[i]) used[i] = 0;
			count = 0;
			idle_to = IDLE_TIMEOUT_RST;
			max_total = MAX_TOTAL_RST;
			max_addr = MAX_PER_ADDR_RST;
		endfunction

		function void drop(int s);
			int unsigned r;
			r = order[s];
			used[s] = 0;
			for (int i = 0; i < SLOTS; i++)
				if (used[i] && order[i] > r) order[i]--;
			if (count > 0) count--;
		endfunction

		function int oldest(bit by_addr, bit [31:0] a, bit [31:0] now);
			int best;
			bit [31:0] best_age, age;
			best = -1;
			best_age = 0;
			for (int i = 0; i < SLOTS; i++) begin
				if (!used[i]) continue;
				if (by_addr && (!active[i] || addr[i] != a)) continue;
				age = now - created[i];
				if (best < 0 || age > best_age || (age == best_age && order[i] < order[best])) begin
					best = i;
					best_age = age;
				end
			end
			return best;
		endfunction

		function bit idle(int s, bit [31:0] now);
			bit [31:0] d;
			d = now - last[s];
			return d > idle_to;
		endfunction

		// note an accepted request and queue its outcome
		function void note_request(bit [2:0] k, bit [31:0] a, bit [63:0] h, bit [63:0] l,
				bit [31:0] now);
			outcome_t o;
			bit empty;
			int s, cnt, lim;
			o = '0;
			o.status = ST_NOMATCH;
			empty = (h == 0 && l == 0);
			case (k)
				KIND_CREATE: begin
					if (empty) o.status = ST_EMPTY;
					else begin
						cnt = 0;
						for (int i = 0; i < SLOTS; i++)
							if (used[i] && active[i] && addr[i] == a) cnt++;
						if (cnt >= max_addr) begin
							s = oldest(1, a, now);
							if (s >= 0) begin drop(s); o.ev_addr = 1; end
						end
						lim = (max_total > SLOTS) ? SLOTS : max_total;
						if (count >= lim) begin
							s = oldest(0, 0, now);
							if (s >= 0) begin drop(s); o.ev_old = 1; end
						end
						if (count >= lim) o.status = ST_EMPTY;
						else begin
							for (s = 0; s < SLOTS && used[s]; s++) ;
							if (s < SLOTS) begin
								used[s] = 1; active[s] = 1; addr[s] = a;
								th[s] = h; tl[s] = l; created[s] = now; last[s] = now;
								order[s] = count;
								count++;
								o.ok = 1;
								o.status = ST_DONE;
							end else o.status = ST_EMPTY;
						end
					end
				end
				KIND_VALIDATE: begin
					if (empty) o.status = ST_EMPTY;
					else begin
						s = -1;
						for (int i = 0; i < SLOTS; i++)
							if (used[i] && active[i] && addr[i] == a && th[i] == h && tl[i] == l
									&& (s < 0 || order[i] < order[s])) s = i;
						if (s >= 0) begin
							if (idle(s, now)) begin
								active[s] = 0;
								o.status = ST_EXPIRED;
							end else begin
								last[s] = now;
								o.ok = 1;
								o.status = ST_VALID;
							end
						end
					end
				end
				KIND_DESTROY: begin
					s = -1;
					for (int i = 0; i < SLOTS; i++)
						if (used[i] && th[i] == h && tl[i] == l && (s < 0 || order[i] < order[s]))
							s = i;
					if (s >= 0) begin drop(s); o.ok = 1; o.status = ST_DONE; end
				end
				KIND_SWEEP: begin
					for (int i = 0; i < SLOTS; i++)
						if (used[i] && (!active[i] || idle(i, now))) drop(i);
					o.ok = 1;
					o.status = ST_DONE;
				end
				KIND_QUERY: begin
					o.ok = 1;
					o.status = ST_DONE;
				end
				default: ;
			endcase
			o.count = count[4:0];
			pending = {pending, o};
		endfunction

		function void check_result(outcome_t got);
			outcome_t want;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	logic pready, start = 0, busy, done;
	logic [2:0] kind = 0;
	logic [31:0] client_address = 0, now_ms = 0;
	logic [63:0] token_high = 0, token_low = 0;
	logic ok, ev_a, ev_o;
	logic [2:0] status;
	logic [4:0] session_count;

	session_board board = new();
	bit [31:0] clock_ms;
	bit [31:0] addr_pool [4];
	bit [63:0] tok_pool [8];
	bit quiet;
	int n_req;

	always begin #1 clk = 1; #1 clk = 0; end

	session_table_with_idle_timeout_top dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.start, .busy, .kind, .client_address, .token_high, .token_low, .now_ms,
		.done, .ok, .status, .evicted_same_address(ev_a), .evicted_oldest(ev_o),
		.session_count
	);

	always @(posedge clk)
		if (arst_n && done) board.check_result({ok, status, ev_a, ev_o, session_count});

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_IDLE_TIMEOUT: board.idle_to = val;
			REG_MAX_TOTAL:    board.max_total = val[4:0];
			default:          board.max_addr = val[4:0];
		endcase
	endtask

	task automatic send(bit [2:0] k, bit [31:0] a, bit [63:0] h, bit [63:0] l, bit [31:0] now);
		if (!quiet) while ($urandom_range(99) < 6) @(posedge clk);
		kind <= k; client_address <= a; token_high <= h; token_low <= l; now_ms <= now;
		start <= 1;
		do @(posedge clk); while (busy);
		board.note_request(k, a, h, l, now);
		n_req++;
		start <= 0;
		// wait for the request to finish so start may be raised cleanly
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic random_phase(int n);
		bit [2:0] k;
		bit [63:0] h, l;
		int r;
		for (int i = 0; i < n; i++) begin
			quiet = (i > n / 2 && i < n / 2 + 100);
			r = $urandom_range(99);
			k = (r < 40) ? KIND_CREATE : (r < 70) ? KIND_VALIDATE : (r < 85) ? KIND_DESTROY :
				(r < 92) ? KIND_SWEEP : (r < 96) ? KIND_QUERY : 3'($urandom_range(7, 5));
			if ($urandom_range(19) == 0) begin
				h = {$urandom, $urandom}; l = {$urandom, $urandom};
			end else if ($urandom_range(29) == 0) begin
				h = 0; l = 0;
			end else begin
				h = tok_pool[$urandom_range(7)]; l = ~h;
			end
			clock_ms += (r % 3 == 0) ? $urandom_range(board.idle_to > 100000 ? 100000 : 50)
				: $urandom_range(20);
			if ($urandom_range(49) == 0) clock_ms = $urandom;
			send(k, ($urandom_range(15) == 0) ? $urandom : addr_pool[$urandom_range(3)],
				h, l, clock_ms);
		end
		quiet = 0;
	endtask

	initial begin
		#200000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		board.clear();
		addr_pool = '{32'h0, 32'hFFFFFFFF, 32'hC0A80001, 32'h0A000002};
		foreach (tok_pool[i]) tok_pool[i] = {$urandom, $urandom};
		tok_pool[0] = 64'hFFFFFFFFFFFFFFFF;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty tokens, unknown kinds, limits, wrap of time
		send(KIND_QUERY, 0, 0, 0, 0);
		send(KIND_CREATE, 1, 0, 0, 0);
		send(KIND_VALIDATE, 1, 0, 0, 0);
		send(KIND_DESTROY, 1, 5, 5, 0);
		for (int i = 0; i < 5; i++) send(KIND_CREATE, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, i, i);
		for (int i = 0; i < 8; i++) send(KIND_CREATE, i, 1, i, 32'hFFFFFFF0 + i);
		send(KIND_VALIDATE, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 4, 10);
		send(KIND_VALIDATE, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 4, 32'h7FFFFFFF);
		send(KIND_VALIDATE, 9, 1, 1, 0);
		send(KIND_SWEEP, 0, 0, 0, 32'h80000000);
		send(KIND_DESTROY, 0, 1, 7, 0);
		for (int k = 5; k < 8; k++) send(3'(k), 0, 0, 0, 0);
		drain();

		clock_ms = 0;
		random_phase(400);
		drain();
		// everything has come out; now change the register settings
		write_reg(REG_IDLE_TIMEOUT, 0);
		write_reg(REG_MAX_TOTAL, 16);
		write_reg(REG_MAX_PER_ADDR, 16);
		random_phase(250);
		drain();
		write_reg(REG_IDLE_TIMEOUT, 32'hFFFFFFFF);
		write_reg(REG_MAX_TOTAL, 1);
		write_reg(REG_MAX_PER_ADDR, 1);
		random_phase(150);
		drain();
		write_reg(REG_IDLE_TIMEOUT, 200);
		write_reg(REG_MAX_TOTAL, 0);
		write_reg(REG_MAX_PER_ADDR, 0);
		random_phase(80);
		drain();
		write_reg(REG_MAX_TOTAL, 31);
		write_reg(REG_MAX_PER_ADDR, 2);
		write_reg(REG_IDLE_TIMEOUT, $urandom_range(5000));
		random_phase(150);
		drain();
		write_reg(REG_MAX_TOTAL, 6);
		write_reg(REG_MAX_PER_ADDR, 31);
		random_phase(150);
		drain();

		$display("Covered %0d requests, %0d results checked, under six register settings",
			n_req, board.checked);
		$display("including zero and full-range limits and idle timeouts.");
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d left over", board.mismatches, board.pending.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
